// File: src/tcw_pkg.sv
// Shared types, codes and sizes for the text console writer.
package tcw_pkg;

  // Default screen geometry.
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Field widths.
  localparam int REQ_W       = 3;
  localparam int CHAR_W      = 8;
  localparam int CELL_IDX_W  = 11;
  localparam int CELL_W      = 16;
  localparam int TOP_ROW_W   = 5;
  localparam int ATTR_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // Register reset values.
  localparam int                   RESET_TOP  = 14;
  localparam logic [ATTR_W-1:0]    RESET_ATTR = 8'h0f;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_TOP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR    = 2'd1;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUT     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_READ    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLR_WIN = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLR_SCR = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SET     = 3'd4;

  // Character codes with a meaning of their own.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [REQ_W-1:0]      req_type;
    logic [CHAR_W-1:0]     char_code;
    logic [CELL_IDX_W-1:0] cell_index;
  } tcw_req_t;

  typedef struct packed {
    logic [CELL_W-1:0]     cell_value;
    logic [CELL_IDX_W-1:0] cursor_pos;
    logic                  serial_valid;
    logic [CHAR_W-1:0]     serial_byte;
  } tcw_res_t;

  typedef struct packed {
    logic [TOP_ROW_W-1:0] top_row;
    logic [ATTR_W-1:0]    attr;
  } tcw_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_NEWLINE,
    ST_MOVE,
    ST_FILL,
    ST_READ_WAIT,
    ST_DONE
  } tcw_state_t;

endpackage

// File: src/text_console_writer_top.sv
// Top level of the text console writer: stream ports, configuration registers, result register.
//
// Requests arrive on the in_ channel, one beat per request; every request gives
// exactly one result beat on the out_ channel. Register writes come on the cfg_
// channel (index 0: window top row, index 1: text attribute), which is always
// ready and must only be used while no request is in flight.
// A request is taken only while the sequencer is idle. An echoed, stored or
// erased character, a cursor set or an unknown request then passes through
// the execute and done steps, a read adds a wait step for the registered RAM
// read data, and the result goes through the result register to out_; the
// sequencer returns to idle before the next request is taken. A newline
// searches for the next row start one row per cycle. A scroll moves the window
// up by one row, one cell per cycle through the single RAM port pair, then
// blanks the bottom row. Clear window blanks from the window start to the end
// of the store and clear screen blanks every cell, one cell written per cycle.
// The result register lets the next request in while an earlier result waits;
// a stalled receiver holds the result, and the sequencer then waits in its
// final step. Reset sets the window top row to 14, the attribute to 0x0f and
// the cursor to the window start; the cell store is not cleared, so a screen
// or window clear should be issued before cells are read.
module text_console_writer_top #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // char_code [7:0], cell_index [18:8], zero pad [23:19]
  input  logic [tcw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // req_type [2:0]
  input  logic [tcw_pkg::REQ_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // cell_value [15:0], cursor_pos [26:16], serial_byte [34:27], zero pad [39:35]
  output logic [tcw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // serial_valid [0]
  output logic                              out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import tcw_pkg::*;

  logic [TOP_ROW_W-1:0] top_row_r;
  logic [ATTR_W-1:0]    attr_r;
  tcw_cfg_t             cfg;
  tcw_req_t             req;
  tcw_res_t             res;
  logic                 res_valid;
  logic                 res_ready;
  logic                 out_valid_r;
  tcw_res_t             out_res_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_row_r <= TOP_ROW_W'(RESET_TOP);
      attr_r    <= RESET_ATTR;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIN_TOP: top_row_r <= cfg_data[TOP_ROW_W-1:0];
        CFG_ATTR:    attr_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.top_row = top_row_r;
  assign cfg.attr    = attr_r;

  assign req.req_type   = in_tuser;
  assign req.char_code  = in_tdata[CHAR_W-1:0];
  assign req.cell_index = in_tdata[CHAR_W +: CELL_IDX_W];

  tcw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r.serial_byte, out_res_r.cursor_pos,
                       out_res_r.cell_value};
  assign out_tuser  = out_res_r.serial_valid;

endmodule

// File: src/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/tcw_seq.sv
// Request sequencer: cursor, newline search, scroll move and fill sweeps over the cell RAM.
module tcw_seq #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tcw_pkg::tcw_cfg_t cfg,
  input  logic             req_valid,
  output logic             req_ready,
  input  tcw_pkg::tcw_req_t req,
  output logic             res_valid,
  input  logic             res_ready,
  output tcw_pkg::tcw_res_t res
);

  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = AW + 1;
  localparam int WW    = (PW > CELL_IDX_W) ? PW : CELL_IDX_W;
  localparam int RESET_TOP_C = (RESET_TOP > ROWS - 1) ? ROWS - 1 : RESET_TOP;
  localparam int RESET_CUR   = RESET_TOP_C * COLUMNS;
  localparam int LAST        = (ROWS - 1) * COLUMNS;

  localparam logic [PW-1:0] CELLS_P = PW'(CELLS);
  localparam logic [PW-1:0] LAST_P  = PW'(LAST);
  localparam logic [PW-1:0] COLS_P  = PW'(COLUMNS);
  localparam logic [WW-1:0] CELLS_W = WW'(CELLS);

  tcw_state_t        state_r, state_nxt;
  tcw_req_t          req_r, req_nxt;
  logic [AW-1:0]     cursor_r, cursor_nxt;
  logic [PW-1:0]     ptr_r, ptr_nxt;
  logic [PW-1:0]     base_r, base_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     paddr_r, paddr_nxt;
  logic [CELL_W-1:0] value_r, value_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic [7:0]        top_ext;
  logic [7:0]        top_sel;
  logic [PW-1:0]     win_start;
  logic [PW-1:0]     cur_p;
  logic [AW-1:0]     cur_m1;
  logic [PW-1:0]     tab_sum;
  logic [PW-1:0]     src_addr;
  logic [WW-1:0]     idx_w;
  logic              idx_ok;
  logic [WW-1:0]     cur_w;
  logic [CELL_W-1:0] blank;
  logic              check;
  logic [PW-1:0]     nc;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // A window top row beyond the last row acts as the last row.
  assign top_ext   = 8'(cfg.top_row);
  assign top_sel   = (top_ext > 8'(ROWS - 1)) ? 8'(ROWS - 1) : top_ext;
  assign win_start = PW'(top_sel * COLUMNS);

  assign cur_p    = PW'(cursor_r);
  assign cur_m1   = cursor_r - 1'b1;
  assign tab_sum  = cur_p + PW'(8);
  assign src_addr = ptr_r + COLS_P;
  assign idx_w    = WW'(req_r.cell_index);
  assign idx_ok   = idx_w < CELLS_W;
  assign cur_w    = WW'(cursor_r);
  assign blank    = {cfg.attr, CH_SPACE};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cursor_r <= AW'(RESET_CUR);
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    ptr_r   <= ptr_nxt;
    base_r  <= base_nxt;
    paddr_r <= paddr_nxt;
    value_r <= value_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    cursor_nxt = cursor_r;
    ptr_nxt    = ptr_r;
    base_nxt   = base_r;
    pend_nxt   = pend_r;
    paddr_nxt  = paddr_r;
    value_nxt  = value_r;
    ram_we     = 1'b0;
    ram_waddr  = cursor_r;
    ram_wdata  = blank;
    ram_raddr  = src_addr[AW-1:0];
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    check      = 1'b0;
    nc         = '0;

    unique case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          req_nxt   = req;
          value_nxt = '0;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (req_r.req_type)
          REQ_PUT: begin
            case (req_r.char_code)
              CH_NUL: state_nxt = ST_DONE;
              CH_BS: begin
                // Backspace stops at the first cell of the window.
                if (cur_p > win_start) begin
                  cursor_nxt = cur_m1;
                  ram_we     = 1'b1;
                  ram_waddr  = cur_m1;
                end
                state_nxt = ST_DONE;
              end
              CH_LF: begin
                base_nxt  = '0;
                state_nxt = ST_NEWLINE;
              end
              CH_TAB: begin
                nc    = {tab_sum[PW-1:3], 3'b000};
                check = 1'b1;
              end
              default: begin
                ram_we    = 1'b1;
                ram_wdata = {cfg.attr, req_r.char_code};
                nc        = cur_p + 1'b1;
                check     = 1'b1;
              end
            endcase
          end
          REQ_READ: begin
            if (idx_ok) begin
              ram_raddr = idx_w[AW-1:0];
              state_nxt = ST_READ_WAIT;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          REQ_CLR_WIN: begin
            ptr_nxt    = win_start;
            cursor_nxt = win_start[AW-1:0];
            state_nxt  = ST_FILL;
          end
          REQ_CLR_SCR: begin
            ptr_nxt    = '0;
            cursor_nxt = win_start[AW-1:0];
            state_nxt  = ST_FILL;
          end
          REQ_SET: begin
            if (idx_ok) begin
              cursor_nxt = idx_w[AW-1:0];
            end
            state_nxt = ST_DONE;
          end
          default: state_nxt = ST_DONE;
        endcase
      end

      // Step a row start up by one row per cycle until it passes the cursor.
      ST_NEWLINE: begin
        if (base_r <= cur_p) begin
          base_nxt = base_r + COLS_P;
        end else begin
          nc    = base_r;
          check = 1'b1;
        end
      end

      // Each cycle reads the cell one row below and writes the cell read
      // in the previous cycle to its new place.
      ST_MOVE: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = paddr_r;
          ram_wdata = ram_rdata;
        end
        if (ptr_r != LAST_P) begin
          ram_raddr = src_addr[AW-1:0];
          pend_nxt  = 1'b1;
          paddr_nxt = ptr_r[AW-1:0];
          ptr_nxt   = ptr_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_FILL;
        end
      end

      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r[AW-1:0];
        if (ptr_r == CELLS_P - 1'b1) begin
          state_nxt = ST_DONE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      ST_READ_WAIT: begin
        value_nxt = ram_rdata;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // A cursor that runs off the end of the store scrolls the window.
    if (check) begin
      if (nc >= CELLS_P) begin
        cursor_nxt = LAST_P[AW-1:0];
        pend_nxt   = 1'b0;
        if (LAST_P > win_start) begin
          ptr_nxt   = win_start;
          state_nxt = ST_MOVE;
        end else begin
          ptr_nxt   = LAST_P;
          state_nxt = ST_FILL;
        end
      end else begin
        cursor_nxt = nc[AW-1:0];
        state_nxt  = ST_DONE;
      end
    end
  end

  assign res.cell_value   = value_r;
  assign res.cursor_pos   = cur_w[CELL_IDX_W-1:0];
  assign res.serial_valid = (req_r.req_type == REQ_PUT);
  assign res.serial_byte  = (req_r.req_type == REQ_PUT) ? req_r.char_code : CH_NUL;

endmodule

// File: sim/text_console_writer_top_tb.sv
// Self-checking testbench for the text console writer: request stream, result stream and registers.
`timescale 1ns / 100ps

module text_console_writer_top_tb;
  import tcw_pkg::*;

  localparam int COLS      = DEF_COLUMNS;
  localparam int ROWS_N    = DEF_ROWS;
  localparam int CELLS     = COLS * ROWS_N;
  localparam int LAST_ROW  = (ROWS_N - 1) * COLS;
  localparam int PHASES    = 8;
  localparam int PHASE_LEN = 135;

  typedef struct packed {
    logic [REQ_W-1:0]      req;
    logic [CHAR_W-1:0]     code;
    logic [CELL_IDX_W-1:0] idx;
    bit                    typed;
    logic [CELL_W-1:0]     val;
    logic [CELL_IDX_W-1:0] cur;
  } dir_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [REQ_W-1:0]       in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // Shadow of the console: cell store, cursor and the two registers.
  logic [CELL_W-1:0] screen_m [0:CELLS-1];
  int unsigned       cursor_m;
  int unsigned       top_m;
  logic [ATTR_W-1:0] attr_m;

  tcw_res_t    result_q [$];
  dir_row_t    dir_rows [$];
  int          fail_cnt    = 0;
  int          sent_cnt    = 0;
  int          checked_cnt = 0;
  int          scroll_cnt  = 0;
  bit          tx_steady   = 1'b0;
  int          rx_calm     = 0;
  int          rx_hold     = 0;

  text_console_writer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned window_start();
    return ((top_m > ROWS_N - 1) ? ROWS_N - 1 : top_m) * COLS;
  endfunction

  function automatic void blank_from(input int unsigned first);
    for (int unsigned i = first; i < CELLS; i++) screen_m[i] = {attr_m, CH_SPACE};
  endfunction

  function automatic void scroll_up();
    for (int unsigned i = window_start(); i < LAST_ROW; i++) screen_m[i] = screen_m[i + COLS];
    blank_from(LAST_ROW);
    cursor_m = LAST_ROW;
    scroll_cnt++;
  endfunction

  function automatic void draw_char(input logic [CHAR_W-1:0] code);
    if (code == CH_NUL) return;
    if (code == CH_BS) begin
      // Backspace never crosses the first cell of the window.
      if (cursor_m > window_start()) begin
        cursor_m--;
        screen_m[cursor_m] = {attr_m, CH_SPACE};
      end
      return;
    end
    if (code == CH_LF) cursor_m = (cursor_m / COLS + 1) * COLS;
    else if (code == CH_TAB) cursor_m = (cursor_m + 8) & ~32'd7;
    else begin
      screen_m[cursor_m] = {attr_m, code};
      cursor_m++;
    end
    if (cursor_m >= CELLS) scroll_up();
  endfunction

  function automatic tcw_res_t console_step(input tcw_req_t r);
    tcw_res_t res;
    res = '0;
    case (r.req_type)
      REQ_PUT: begin
        res.serial_valid = 1'b1;
        res.serial_byte  = r.char_code;
        draw_char(r.char_code);
      end
      REQ_READ: if (r.cell_index < CELLS) res.cell_value = screen_m[r.cell_index];
      REQ_CLR_WIN: begin
        blank_from(window_start());
        cursor_m = window_start();
      end
      REQ_CLR_SCR: begin
        blank_from(0);
        cursor_m = window_start();
      end
      REQ_SET: if (r.cell_index < CELLS) cursor_m = 32'(r.cell_index);
      default: ;
    endcase
    res.cursor_pos = cursor_m[CELL_IDX_W-1:0];
    return res;
  endfunction

  function automatic void add_row(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] code,
                                  input logic [CELL_IDX_W-1:0] idx, input bit typed,
                                  input logic [CELL_W-1:0] val,
                                  input logic [CELL_IDX_W-1:0] cur);
    dir_row_t d;
    d.req   = req;
    d.code  = code;
    d.idx   = idx;
    d.typed = typed;
    d.val   = val;
    d.cur   = cur;
    dir_rows.push_back(d);
  endfunction

  function automatic int tx_gap();
    int pick;
    if (tx_steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly put-char traffic, steered so the cursor often reaches the bottom
  // row and the window start, where scrolls and blocked backspaces happen.
  function automatic tcw_req_t random_req();
    tcw_req_t r;
    int       pick;
    int       pos;
    r.req_type   = REQ_PUT;
    r.char_code  = CHAR_W'($urandom_range(0, 255));
    r.cell_index = CELL_IDX_W'($urandom_range(0, 2047));
    pick = $urandom_range(0, 99);
    if (pick < 68) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) r.char_code = CH_LF;
      else if (pick < 16) r.char_code = CH_TAB;
      else if (pick < 24) r.char_code = CH_BS;
      else if (pick < 27) r.char_code = CH_NUL;
    end else if (pick < 80) begin
      r.req_type = REQ_READ;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        pos = int'(cursor_m) + int'($urandom_range(0, 80)) - 40;
        if (pos < 0) pos = 0;
        if (pos > CELLS - 1) pos = CELLS - 1;
        r.cell_index = CELL_IDX_W'(pos);
      end else if (pick < 58) r.cell_index = CELL_IDX_W'($urandom_range(CELLS, 2047));
      else r.cell_index = CELL_IDX_W'($urandom_range(0, CELLS - 1));
    end else if (pick < 90) begin
      r.req_type = REQ_SET;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        r.cell_index = CELL_IDX_W'(LAST_ROW - COLS + $urandom_range(0, 2 * COLS - 1));
      end else if (pick < 70) begin
        pos = int'(window_start()) + int'($urandom_range(0, 4)) - 2;
        r.cell_index = CELL_IDX_W'((pos < 0) ? 0 : pos);
      end else if (pick < 90) r.cell_index = CELL_IDX_W'($urandom_range(0, 2047));
      else r.cell_index = CELL_IDX_W'($urandom_range(CELLS, 2047));
    end else if (pick < 93) r.req_type = REQ_CLR_WIN;
    else if (pick < 94) r.req_type = REQ_CLR_SCR;
    else if (pick < 97) r.req_type = REQ_W'($urandom_range(5, 7));
    return r;
  endfunction

  task automatic send_req(input tcw_req_t r, input bit typed, input tcw_res_t typed_res);
    tcw_res_t want;
    int       gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.req_type;
    in_tdata  <= {{(IN_TDATA_W - CELL_IDX_W - CHAR_W){1'b0}}, r.cell_index, r.char_code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = console_step(r);
    result_q.push_back(typed ? typed_res : want);
    sent_cnt++;
  endtask

  // Registers change only once every result is back; cfg_valid stays high
  // across both beats.
  task automatic set_console(input logic [TOP_ROW_W-1:0] top, input logic [ATTR_W-1:0] attr);
    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_WIN_TOP;
    cfg_data  <= {{(CFG_DATA_W - TOP_ROW_W){1'b0}}, top};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    top_m     = 32'(top);
    cfg_index <= CFG_ATTR;
    cfg_data  <= attr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    attr_m    = attr;
    cfg_valid <= 1'b0;
  endtask

  task automatic report_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin : rx_side
    tcw_res_t got;
    tcw_res_t want;
    int       pick;
    if (rst_n && out_tvalid && out_tready) begin
      got.cell_value   = out_tdata[15:0];
      got.cursor_pos   = out_tdata[26:16];
      got.serial_byte  = out_tdata[34:27];
      got.serial_valid = out_tuser;
      if (result_q.size() == 0) begin
        report_fail($sformatf("result beat with nothing pending: tdata %h tuser %b",
                              out_tdata, out_tuser));
      end else begin
        want = result_q.pop_front();
        if (got !== want)
          report_fail($sformatf({"result %0d: cell %h/%h cursor %0d/%0d serial_valid %b/%b",
                                 " serial_byte %h/%h (expected/actual)"}, checked_cnt,
                                want.cell_value, got.cell_value, want.cursor_pos,
                                got.cursor_pos, want.serial_valid, got.serial_valid,
                                want.serial_byte, got.serial_byte));
      end
      checked_cnt++;
    end
    // Receiver: mostly ready, short and occasional long stalls, calm stretches.
    if (rx_calm > 0) begin
      rx_calm--;
      out_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 4) rx_calm = $urandom_range(40, 200);
      else if (pick < 26) rx_hold = $urandom_range(1, 4);
      else if (pick < 29) rx_hold = $urandom_range(20, 60);
      out_tready <= (pick < 4) || (pick >= 29);
    end
  end

  initial begin : stimulus
    tcw_req_t r;
    tcw_res_t typed_res;
    dir_row_t d;
    for (int i = 0; i < CELLS; i++) screen_m[i] = '0;
    top_m    = RESET_TOP;
    attr_m   = RESET_ATTR;
    cursor_m = window_start();

    // The first beat writes a cell before anything is cleared; the screen
    // clear that follows defines every cell before the first read.
    add_row(REQ_PUT,     8'h41,  11'd0,    1'b1, 16'h0000, 11'd1121);
    add_row(REQ_CLR_SCR, 8'h00,  11'd0,    1'b1, 16'h0000, 11'd1120);
    add_row(REQ_READ,    8'h00,  11'd1121, 1'b1, 16'h0f20, 11'd1120);
    add_row(REQ_READ,    8'hff,  11'd2047, 1'b1, 16'h0000, 11'd1120);
    add_row(REQ_SET,     8'h00,  11'd2047, 1'b1, 16'h0000, 11'd1120);
    add_row(REQ_PUT,     CH_BS,  11'd0,    1'b1, 16'h0000, 11'd1120);
    add_row(REQ_PUT,     CH_NUL, 11'd0,    1'b1, 16'h0000, 11'd1120);
    add_row(REQ_PUT,     8'hff,  11'd0,    1'b1, 16'h0000, 11'd1121);
    add_row(REQ_PUT,     CH_BS,  11'd0,    1'b1, 16'h0000, 11'd1120);
    add_row(REQ_READ,    8'h00,  11'd1120, 1'b1, 16'h0f20, 11'd1120);
    add_row(REQ_PUT,     CH_TAB, 11'd0,    1'b1, 16'h0000, 11'd1128);
    add_row(REQ_PUT,     CH_LF,  11'd0,    1'b1, 16'h0000, 11'd1200);
    add_row(REQ_SET,     8'h00,  11'd0,    1'b1, 16'h0000, 11'd0);
    add_row(REQ_PUT,     CH_BS,  11'd0,    1'b1, 16'h0000, 11'd0);
    add_row(REQ_PUT,     8'h7e,  11'd0,    1'b0, 16'h0000, 11'd0);
    add_row(REQ_READ,    8'h00,  11'd0,    1'b1, 16'h0f7e, 11'd1);
    add_row(REQ_SET,     8'h00,  11'd1999, 1'b1, 16'h0000, 11'd1999);
    add_row(REQ_PUT,     8'h5a,  11'd0,    1'b1, 16'h0000, 11'd1920);
    add_row(REQ_READ,    8'h00,  11'd1919, 1'b0, 16'h0000, 11'd0);
    add_row(REQ_SET,     8'h00,  11'd1999, 1'b1, 16'h0000, 11'd1999);
    add_row(REQ_PUT,     CH_TAB, 11'd0,    1'b1, 16'h0000, 11'd1920);
    add_row(REQ_PUT,     CH_LF,  11'd0,    1'b1, 16'h0000, 11'd1920);
    add_row(3'd7,        8'hff,  11'd2047, 1'b1, 16'h0000, 11'd1920);
    add_row(3'd5,        8'h00,  11'd0,    1'b1, 16'h0000, 11'd1920);
    add_row(REQ_CLR_WIN, 8'h00,  11'd0,    1'b1, 16'h0000, 11'd1120);
    add_row(REQ_READ,    8'h00,  11'd1999, 1'b1, 16'h0f20, 11'd1120);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      d = dir_rows[i];
      r.req_type   = d.req;
      r.char_code  = d.code;
      r.cell_index = d.idx;
      typed_res.cell_value   = d.val;
      typed_res.cursor_pos   = d.cur;
      typed_res.serial_valid = (d.req == REQ_PUT);
      typed_res.serial_byte  = (d.req == REQ_PUT) ? d.code : '0;
      send_req(r, d.typed, typed_res);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_console(5'd0, 8'h00);
        1: set_console(5'd24, 8'hff);
        2: set_console(5'd31, 8'ha5);
        3: set_console(5'd25, 8'h5a);
        6: set_console(TOP_ROW_W'(RESET_TOP), RESET_ATTR);
        default: set_console(TOP_ROW_W'($urandom_range(0, 31)),
                             ATTR_W'($urandom_range(0, 255)));
      endcase
      // One phase runs the sender back to back.
      tx_steady = (p == 5);
      repeat (PHASE_LEN) send_req(random_req(), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d requests (%0d directed) over %0d register settings.",
             sent_cnt, dir_rows.size(), PHASES + 1);
    $display("Checked %0d result beats; the window scrolled %0d times; %0d mismatches.",
             checked_cnt, scroll_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // About 1100 requests, each at worst a full-screen walk plus the longest
  // stalls, must finish before this limit.
  initial begin : watchdog
    #(100_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
